### rtl/frls_pkg.sv
// ----------------------------------------------------------------------------
// frls_pkg: shared types and constants of the flash record log scanner
// Record layout constants, result codes, the scan handoff structs and the
// word-wide reflected CRC-32 update.
// ----------------------------------------------------------------------------
package frls_pkg;

  localparam int unsigned PAGE_WORDS = 256;
  localparam int unsigned COUNT_W    = $clog2(PAGE_WORDS + 1);

  localparam logic [31:0] REC_MAGIC   = 32'h3157_4656;
  localparam logic [15:0] REC_VERSION = 16'd1;
  localparam logic [15:0] REC_LENGTH  = 16'd12;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    STATUS_NONE   = 2'd0,
    STATUS_RECORD = 2'd1,
    STATUS_LEGACY = 2'd2
  } status_t;

  // One page word handed to the scan core
  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } scan_in_t;

  // Result of a page, formed on its last word
  typedef struct packed {
    status_t            status;
    logic [31:0]        scale_bits;
    logic signed [31:0] zero_offset;
    logic [31:0]        target_bits;
    logic [31:0]        sequence_res;
  } scan_result_t;

  // Reflected CRC-32 over four little-endian bytes of w, byte 0 first.
  // Linear in both arguments, so it flattens into an XOR network.
  function automatic logic [31:0] crc32_word(input logic [31:0] crc,
                                             input logic [31:0] w);
    logic [31:0] c;
    c = crc ^ w;
    for (int i = 0; i < 32; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/frls_if.sv
// ----------------------------------------------------------------------------
// frls_if: valid/ready channels of the flash record log scanner
// page_if carries page words in, result_if carries page results out.
// ----------------------------------------------------------------------------
interface page_if;
  logic        valid;
  logic        ready;
  logic [31:0] page_word;
  logic        page_end;

  modport source (output valid, output page_word, output page_end, input ready);
  modport sink   (input valid, input page_word, input page_end, output ready);
endinterface

interface result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [31:0]        scale_bits;
  logic signed [31:0] zero_offset;
  logic [31:0]        target_bits;
  logic [31:0]        sequence_res;

  modport source (output valid, output status, output scale_bits, output zero_offset,
                  output target_bits, output sequence_res, input ready);
  modport sink   (input valid, input status, input scale_bits, input zero_offset,
                  input target_bits, input sequence_res, output ready);
endinterface

### rtl/frls_scan_core.sv
// ----------------------------------------------------------------------------
// frls_scan_core: record parser and newest-record tracker
// Walks the seven-word records of a page one word per step, checks header
// and CRC, keeps the newest valid record and forms the page result.
// ----------------------------------------------------------------------------
module frls_scan_core import frls_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  scan_in_t     scan_in,
  input  logic [7:0]   legacy_marker,
  output scan_result_t result
);

  logic [2:0]         word_position, word_position_next;
  logic               scan_stopped, scan_stopped_next;
  logic [31:0]        running_crc, running_crc_next;
  logic               header_ok, header_ok_next;
  logic [31:0]        current_sequence, current_sequence_next;
  logic [31:0]        stored_crc, stored_crc_next;
  logic [31:0]        current_payload [3];
  logic [31:0]        current_payload_next [3];
  logic               found_any, found_any_next;
  logic [31:0]        best_sequence, best_sequence_next;
  logic [31:0]        best_payload [3];
  logic [31:0]        best_payload_next [3];
  logic [31:0]        first_page_words [4];
  logic [COUNT_W-1:0] word_count, word_count_next;

  logic        in_page;
  logic        scan_active;
  logic [31:0] crc_upd;
  logic [31:0] legacy_word [4];

  assign in_page     = word_count < COUNT_W'(PAGE_WORDS);
  assign scan_active = in_page && !scan_stopped;
  assign crc_upd     = crc32_word(running_crc, scan_in.word);

  always_comb begin
    word_position_next    = word_position;
    scan_stopped_next     = scan_stopped;
    running_crc_next      = running_crc;
    header_ok_next        = header_ok;
    current_sequence_next = current_sequence;
    stored_crc_next       = stored_crc;
    current_payload_next  = current_payload;
    found_any_next        = found_any;
    best_sequence_next    = best_sequence;
    best_payload_next     = best_payload;
    word_count_next       = in_page ? word_count + COUNT_W'(1) : word_count;

    if (scan_active) begin
      unique case (word_position)
        3'd0: begin
          if (scan_in.word != REC_MAGIC) begin
            scan_stopped_next = 1'b1;
          end else begin
            running_crc_next   = ALL_ONES;
            word_position_next = 3'd1;
          end
        end
        3'd1: begin
          header_ok_next     = (scan_in.word[15:0] == REC_VERSION) &&
                               (scan_in.word[31:16] == REC_LENGTH);
          running_crc_next   = crc_upd;
          word_position_next = 3'd2;
        end
        3'd2: begin
          current_sequence_next = scan_in.word;
          running_crc_next      = crc_upd;
          word_position_next    = 3'd3;
        end
        3'd3: begin
          stored_crc_next    = scan_in.word;
          word_position_next = 3'd4;
        end
        3'd4: begin
          current_payload_next[0] = scan_in.word;
          running_crc_next        = crc_upd;
          word_position_next      = 3'd5;
        end
        3'd5: begin
          current_payload_next[1] = scan_in.word;
          running_crc_next        = crc_upd;
          word_position_next      = 3'd6;
        end
        default: begin
          current_payload_next[2] = scan_in.word;
          running_crc_next        = crc_upd;
          word_position_next      = 3'd0;
          // keep the record on a good header and CRC; ties keep the earlier one
          if (header_ok && (~crc_upd == stored_crc) &&
              (!found_any || (current_sequence > best_sequence))) begin
            found_any_next       = 1'b1;
            best_sequence_next   = current_sequence;
            best_payload_next[0] = current_payload[0];
            best_payload_next[1] = current_payload[1];
            best_payload_next[2] = scan_in.word;
          end
        end
      endcase
    end
  end

  // Old-layout words as seen after this word; words the page never held read as 0
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (word_count_next > COUNT_W'(i)) begin
        legacy_word[i] = (in_page && (word_count == COUNT_W'(i))) ?
                         scan_in.word : first_page_words[i];
      end else begin
        legacy_word[i] = '0;
      end
    end
  end

  always_comb begin
    result = '0;
    if (found_any_next) begin
      result.status       = STATUS_RECORD;
      result.scale_bits   = best_payload_next[0];
      result.zero_offset  = best_payload_next[1];
      result.target_bits  = best_payload_next[2];
      result.sequence_res = best_sequence_next;
    end else if (legacy_word[3][7:0] == legacy_marker) begin
      result.status      = STATUS_LEGACY;
      result.scale_bits  = legacy_word[0];
      result.zero_offset = legacy_word[1];
      result.target_bits = legacy_word[2];
    end
  end

  // Control state: restart the scan after the last word of each page
  always_ff @(posedge clk) begin
    if (rst) begin
      word_position    <= '0;
      scan_stopped     <= 1'b0;
      running_crc      <= ALL_ONES;
      header_ok        <= 1'b0;
      current_sequence <= '0;
      stored_crc       <= '0;
      found_any        <= 1'b0;
      best_sequence    <= '0;
      word_count       <= '0;
    end else if (step) begin
      if (scan_in.last) begin
        word_position    <= '0;
        scan_stopped     <= 1'b0;
        running_crc      <= ALL_ONES;
        header_ok        <= 1'b0;
        current_sequence <= '0;
        stored_crc       <= '0;
        found_any        <= 1'b0;
        best_sequence    <= '0;
        word_count       <= '0;
      end else begin
        word_position    <= word_position_next;
        scan_stopped     <= scan_stopped_next;
        running_crc      <= running_crc_next;
        header_ok        <= header_ok_next;
        current_sequence <= current_sequence_next;
        stored_crc       <= stored_crc_next;
        found_any        <= found_any_next;
        best_sequence    <= best_sequence_next;
        word_count       <= word_count_next;
      end
    end
  end

  // Payload holding registers
  always_ff @(posedge clk) begin
    if (step) begin
      current_payload <= current_payload_next;
      best_payload    <= best_payload_next;
      if (in_page && (word_count < COUNT_W'(4))) begin
        first_page_words[word_count[1:0]] <= scan_in.word;
      end
    end
  end

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    word_position <= 3'd6)
    else $error("record word position out of range");

  a_page_restart: assert property (@(posedge clk) disable iff (rst)
    step && scan_in.last |=> (word_count == '0) && !found_any && !scan_stopped)
    else $error("scan state not cleared after page end");

  a_stopped_at_start: assert property (@(posedge clk) disable iff (rst)
    scan_stopped |-> (word_position == 3'd0))
    else $error("scan stopped in the middle of a record");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    word_count <= COUNT_W'(PAGE_WORDS))
    else $error("word counter past page size");

endmodule

### rtl/frls_out_reg.sv
// ----------------------------------------------------------------------------
// frls_out_reg: result holding register
// Holds one page result until the sink takes it.
// ----------------------------------------------------------------------------
module frls_out_reg import frls_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  scan_result_t load_data,
  output logic         free,
  result_if.source     result
);

  logic         valid;
  scan_result_t data;

  assign free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

  assign result.valid        = valid;
  assign result.status       = data.status;
  assign result.scale_bits   = data.scale_bits;
  assign result.zero_offset  = data.zero_offset;
  assign result.target_bits  = data.target_bits;
  assign result.sequence_res = data.sequence_res;

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result overwritten before it was taken");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    valid && !result.ready && !load |=> valid && $stable(data))
    else $error("stalled result lost");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    valid && result.ready && !load |=> !valid)
    else $error("taken result shown twice");

endmodule

### rtl/flash_record_log_scanner.sv
// ----------------------------------------------------------------------------
// flash_record_log_scanner: newest-record finder for one flash page
// Path: page_end word -> input register -> scan logic -> output register.
// Throughput: 1 page word per cycle, but a page_end word waits while the
//   result register is full; the word-wide CRC-32 XOR network and the
//   record compare sit in the one stage between the two registers.
// Reset (rst, synchronous): empties both registers, restarts the scan, and
//   sets legacy_marker to 0. No clearing pass is needed.
// ----------------------------------------------------------------------------
module flash_record_log_scanner import frls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  page_if.sink       page,
  result_if.source   result
);

  // Marker byte that validates the old unversioned layout
  logic [7:0] legacy_marker;

  // Input register stage
  logic     s1_valid;
  scan_in_t s1_data;
  logic     s1_advance;

  logic         out_free;
  scan_result_t scan_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      legacy_marker <= '0;
    end else if (cfg_we) begin
      legacy_marker <= cfg_wdata;
    end
  end

  // A word without page_end never waits; the last word waits only for a
  // free result register, which frees up in the same cycle it is taken.
  assign s1_advance = s1_valid && (!s1_data.last || out_free);
  assign page.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (page.ready) begin
      s1_valid <= page.valid;
    end
  end

  // Capture the word on acceptance; hold it while stalled
  always_ff @(posedge clk) begin
    if (page.valid && page.ready) begin
      s1_data.word <= page.page_word;
      s1_data.last <= page.page_end;
    end
  end

  frls_scan_core u_scan (
    .clk           (clk),
    .rst           (rst),
    .step          (s1_advance),
    .scan_in       (s1_data),
    .legacy_marker (legacy_marker),
    .result        (scan_result)
  );

  // Load a result only on the last word of a page
  frls_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_advance && s1_data.last),
    .load_data (scan_result),
    .free      (out_free),
    .result    (result)
  );

  a_stall_holds_word: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_data))
    else $error("held page word changed or dropped");

  a_only_last_stalls: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |-> s1_data.last && !out_free)
    else $error("input stage stalled without cause");

  a_result_on_last: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_data.last |=> result.valid)
    else $error("page end gave no result");

endmodule
